/* sv/lsac_pkg.sv */
// Shared types and constants of the set-associative LRU cache lookup.
package lsac_pkg;

   localparam int NUM_WAYS = 4;
   localparam int NUM_SETS = 64;
   localparam int TAG_BITS = 20;
   localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int REQ_TAG_BITS = 20;
   localparam int REQ_SET_BITS = 6;
   localparam int CNT_BITS = 32;

   typedef logic [WAY_BITS-1:0] way_type;
   typedef way_type [NUM_WAYS-1:0] order_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic respond;
   } cmd_type;

   function automatic order_type reset_order();
      order_type o;
      for (int p = 0; p < NUM_WAYS; p++) begin
         o[p] = way_type'(p);
      end
      return o;
   endfunction

endpackage

/* sv/lsac_ctrl.sv */
// Controller state machine: capture, read, update and respond steps.
module lsac_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output lsac_pkg::cmd_type cmd
);

   lsac_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsac_pkg::ST_IDLE:   if (start) state_in = lsac_pkg::ST_READ;
         lsac_pkg::ST_READ:   state_in = lsac_pkg::ST_UPDATE;
         lsac_pkg::ST_UPDATE: state_in = lsac_pkg::ST_IDLE;
         default:             state_in = lsac_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != lsac_pkg::ST_IDLE);
      cmd.capture = (state_ff == lsac_pkg::ST_IDLE) && start;
      cmd.update  = (state_ff == lsac_pkg::ST_UPDATE);
      cmd.respond = (state_ff == lsac_pkg::ST_UPDATE);
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == lsac_pkg::ST_READ)
      else $error("capture did not enter read");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == lsac_pkg::ST_READ |=> cmd.update)
      else $error("read not followed by update");
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> !busy)
      else $error("update not followed by idle");

endmodule

/* sv/lsac_datapath.sv */
// Tag, valid, dirty and LRU stores with lookup, replacement and counters.
module lsac_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsac_pkg::cmd_type                     cmd,
   input  logic                                  req_kind,
   input  logic [lsac_pkg::REQ_TAG_BITS-1:0]     req_tag,
   input  logic [lsac_pkg::REQ_SET_BITS-1:0]     req_set_index,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic                                  rsp_dirty_eviction,
   output logic                                  rsp_set_full,
   output logic [lsac_pkg::CNT_BITS-1:0]         rsp_hit_total,
   output logic [lsac_pkg::CNT_BITS-1:0]         rsp_miss_total,
   output logic [lsac_pkg::CNT_BITS-1:0]         rsp_dirty_eviction_total
);

   localparam int NW = lsac_pkg::NUM_WAYS;
   localparam int NS = lsac_pkg::NUM_SETS;
   localparam int TB = lsac_pkg::TAG_BITS;
   localparam int SB = lsac_pkg::SET_BITS;

   // per-set rows in memories, no reset
   logic [NW-1:0][TB-1:0] tag_mem [NS];
   logic [NW-1:0]         valid_mem [NS];
   logic [NW-1:0]         dirty_mem [NS];
   lsac_pkg::order_type   order_mem [NS];
   // a set never touched since reset reads as empty, ways in index order
   logic [NS-1:0]         touched_ff;

   logic [NW-1:0][TB-1:0] tag_row_ff;
   logic [NW-1:0]         valid_row_ff, dirty_row_ff;
   lsac_pkg::order_type   order_row_ff;
   logic                  touched_row_ff;

   logic                  kind_ff;
   logic [TB-1:0]         tag_ff;
   logic [SB-1:0]         set_ff;
   logic [SB-1:0]         set_in;
   logic [TB-1:0]         tag_in;

   logic [lsac_pkg::CNT_BITS-1:0] hit_cnt_ff, miss_cnt_ff, dev_cnt_ff;
   logic                  rsp_valid_ff, hit_out_ff, dev_out_ff, full_out_ff;

   // request capture, reduced to the configured set and tag widths
   always_comb begin
      if (NS > 1) begin
         set_in = SB'(int'(req_set_index) % NS);
      end else begin
         set_in = '0;
      end
      tag_in = TB'(req_tag);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff        <= req_kind;
         tag_ff         <= tag_in;
         set_ff         <= set_in;
         tag_row_ff     <= tag_mem[set_in];
         valid_row_ff   <= valid_mem[set_in];
         dirty_row_ff   <= dirty_mem[set_in];
         order_row_ff   <= order_mem[set_in];
         touched_row_ff <= touched_ff[set_in];
      end
   end

   // lookup on registered row
   logic [NW-1:0]        v_row, d_row, match;
   lsac_pkg::order_type  o_row, o_new;
   logic                 hit;
   lsac_pkg::way_type    hit_way, inv_way, way;
   logic                 any_inv, dev;
   logic [NW-1:0]        v_new, d_new;
   lsac_pkg::way_type    pos;

   always_comb begin
      v_row = touched_row_ff ? valid_row_ff : '0;
      d_row = touched_row_ff ? dirty_row_ff : '0;
      o_row = touched_row_ff ? order_row_ff : lsac_pkg::reset_order();
      hit = 1'b0;
      hit_way = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         match[w] = v_row[w] && (tag_row_ff[w] == tag_ff);
         if (match[w]) begin
            hit = 1'b1;
            hit_way = lsac_pkg::way_type'(w);
         end
      end
      any_inv = 1'b0;
      inv_way = '0;
      for (int w = NW - 1; w >= 0; w--) begin
         if (!v_row[w]) begin
            any_inv = 1'b1;
            inv_way = lsac_pkg::way_type'(w);
         end
      end
      if (hit) way = hit_way;
      else if (any_inv) way = inv_way;
      else way = o_row[NW-1];
      dev = !hit && !any_inv && d_row[way];
      pos = lsac_pkg::way_type'(NW - 1);
      for (int p = NW - 1; p >= 0; p--) begin
         if (o_row[p] == way) pos = lsac_pkg::way_type'(p);
      end
      for (int p = 0; p < NW; p++) begin
         if (p == 0) o_new[p] = way;
         else if (lsac_pkg::way_type'(p) <= pos) o_new[p] = o_row[p-1];
         else o_new[p] = o_row[p];
      end
      v_new = v_row;
      v_new[way] = 1'b1;
      d_new = d_row;
      if (hit) d_new[way] = d_row[way] | kind_ff;
      else d_new[way] = kind_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.update && !hit) begin
         tag_mem[set_ff][way] <= tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         valid_mem[set_ff] <= v_new;
         dirty_mem[set_ff] <= d_new;
         order_mem[set_ff] <= o_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff   <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         dev_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.update) begin
            touched_ff[set_ff] <= 1'b1;
            if (hit) hit_cnt_ff <= hit_cnt_ff + lsac_pkg::CNT_BITS'(1);
            else miss_cnt_ff <= miss_cnt_ff + lsac_pkg::CNT_BITS'(1);
            if (dev) dev_cnt_ff <= dev_cnt_ff + lsac_pkg::CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         hit_out_ff  <= hit;
         dev_out_ff  <= dev;
         full_out_ff <= &v_new;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_hit                  = hit_out_ff;
   assign rsp_dirty_eviction       = dev_out_ff;
   assign rsp_set_full             = full_out_ff;
   assign rsp_hit_total            = hit_cnt_ff;
   assign rsp_miss_total           = miss_cnt_ff;
   assign rsp_dirty_eviction_total = dev_cnt_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_dirty_eviction))
      else $error("dirty eviction reported on a hit");
   assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $onehot0(match))
      else $error("tag matched in more than one way");
   assert property (@(posedge clock) disable iff (reset)
      cmd.update && hit |=> miss_cnt_ff == $past(miss_cnt_ff))
      else $error("miss counted on a hit");

endmodule

/* sv/lru_set_assoc_cache_lookup.sv */
// Top level of the set-associative LRU cache lookup (tags and status only).
//
// Each transaction is one access (read or write of a tag in a set). Raise
// start while busy is low; the access is taken at that edge and busy stays
// high through the read and update states. The tag, valid, dirty and LRU
// rows of the set are read into registers at the accepting edge, compared
// in the read and update states and written back at the end of the update
// state. The result appears for exactly one cycle on rsp_valid in the cycle
// after that, as busy drops. The receiver cannot stall: it must take the
// result in that cycle. The rsp_*_total counters wrap at 2^32 and include
// the access being reported. A per-set touched bit, cleared by reset, makes
// the rows of sets not yet accessed read as empty with ways in index order,
// so no clearing pass is needed; tags read from never-filled ways are masked
// by their valid bits.
module lru_set_assoc_cache_lookup (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [lsac_pkg::REQ_TAG_BITS-1:0] req_tag,
   input  logic [lsac_pkg::REQ_SET_BITS-1:0] req_set_index,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic                              rsp_dirty_eviction,
   output logic                              rsp_set_full,
   output logic [lsac_pkg::CNT_BITS-1:0]     rsp_hit_total,
   output logic [lsac_pkg::CNT_BITS-1:0]     rsp_miss_total,
   output logic [lsac_pkg::CNT_BITS-1:0]     rsp_dirty_eviction_total
);

   lsac_pkg::cmd_type cmd;

   lsac_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lsac_datapath u_dp (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .req_kind                 (req_kind),
      .req_tag                  (req_tag),
      .req_set_index            (req_set_index),
      .rsp_valid                (rsp_valid),
      .rsp_hit                  (rsp_hit),
      .rsp_dirty_eviction       (rsp_dirty_eviction),
      .rsp_set_full             (rsp_set_full),
      .rsp_hit_total            (rsp_hit_total),
      .rsp_miss_total           (rsp_miss_total),
      .rsp_dirty_eviction_total (rsp_dirty_eviction_total)
   );

endmodule
